// File: rtl/dahr_envelope_generator_macros.svh
// assertion macros shared by the envelope generator modules
`ifndef DAHR_ENVELOPE_GENERATOR_MACROS_SVH
`define DAHR_ENVELOPE_GENERATOR_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define DAHR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define DAHR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dahr_pkg.sv
// shared constants and controller/datapath types of the envelope generator
`default_nettype none

package dahr_pkg;

   localparam int FRAME_BITS_DEFAULT      = 24;
   localparam int LEVEL_FRAC_BITS_DEFAULT = 32;

   localparam int ACTION_W    = 2;
   localparam int SEG_W       = 3;
   localparam int MODE_W      = 2;
   localparam int OUT_LEVEL_W = 17;
   localparam int CSR_INDEX_W = 3;

   // actions
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_KEY_ON  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_KEY_OFF = 2'd2;

   // segments
   localparam logic [SEG_W-1:0] SEG_IDLE    = 3'd0;
   localparam logic [SEG_W-1:0] SEG_DELAY   = 3'd1;
   localparam logic [SEG_W-1:0] SEG_ATTACK  = 3'd2;
   localparam logic [SEG_W-1:0] SEG_HOLD    = 3'd3;
   localparam logic [SEG_W-1:0] SEG_RELEASE = 3'd4;

   // envelope modes
   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MODE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_ENA = 3'd4;

   typedef struct packed {
      logic             capture;
      logic             frame_step;
      logic             key_on;
      logic             enter;
      logic             div_start;
      logic             slope_load;
      logic             apply;
      logic             load_rsp;
      logic [SEG_W-1:0] seg_sel;
   } dahr_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SEG_W-1:0]    segment;
      logic                expiring;
      logic                ignore_flag;
      logic [MODE_W-1:0]   mode;
      logic                release_enable;
      logic                delay_zero;
      logic                attack_zero;
      logic                release_zero;
      logic                div_done;
   } dahr_status_type;

endpackage

`default_nettype wire

// File: rtl/dahr_if.sv
// valid/ready channel interfaces: request, response and register write
`default_nettype none

interface dahr_req_if;
   logic                           valid;
   logic                           ready;
   logic [dahr_pkg::ACTION_W-1:0]  action;
   logic                           ignore_release;

   modport source (output valid, output action, output ignore_release, input ready);
   modport sink (input valid, input action, input ignore_release, output ready);
endinterface

interface dahr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [dahr_pkg::OUT_LEVEL_W-1:0] level;
   logic [dahr_pkg::SEG_W-1:0]       segment;

   modport source (output valid, output level, output segment, input ready);
   modport sink (input valid, input level, input segment, output ready);
endinterface

interface dahr_csr_if #(
   parameter int DATA_W = dahr_pkg::FRAME_BITS_DEFAULT
);
   logic                             valid;
   logic                             ready;
   logic [dahr_pkg::CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]                data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/dahr_div.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module dahr_div #(
   parameter int DIVIDEND_W = dahr_pkg::LEVEL_FRAC_BITS_DEFAULT + 1,
   parameter int DIVISOR_W  = dahr_pkg::FRAME_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CW = $clog2(DIVIDEND_W);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CW-1:0]         cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  den_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_diff;
   logic                  fits;
   logic                  last_step;

   assign last_step = busy_ff && (cnt_ff == '0);

   always_comb begin
      trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits       = (trial >= {1'b0, den_ff});
      trial_diff = trial - {1'b0, den_ff};
      rem_in     = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_in     = {quo_ff[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DIVIDEND_W - 1);
         end else if (busy_ff) begin
            busy_ff <= !last_step;
            cnt_ff  <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/dahr_ctrl.sv
// sequencing state machine: decodes a word, steps segments, drives the datapath
`default_nettype none

module dahr_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire dahr_pkg::dahr_status_type status,
   output dahr_pkg::dahr_cmd_type         cmd
);

`include "dahr_envelope_generator_macros.svh"

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_ENTER  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_APPLY  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [dahr_pkg::SEG_W-1:0] nxt_seg_ff, nxt_seg_in;
   logic                       apply_ff, apply_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       advance;
   logic [dahr_pkg::SEG_W-1:0] adv_seg;
   logic                       frames_zero;
   logic                       needs_div;
   logic                       out_free;

   // segment that follows on expiry, by mode
   always_comb begin
      advance = 1'b0;
      adv_seg = status.segment + 1'b1;
      case (status.mode)
         dahr_pkg::MODE_NORMAL: begin
            advance = status.segment inside {dahr_pkg::SEG_DELAY, dahr_pkg::SEG_ATTACK,
                                             dahr_pkg::SEG_HOLD};
         end
         dahr_pkg::MODE_HOLD: begin
            advance = (status.segment == dahr_pkg::SEG_DELAY);
         end
         dahr_pkg::MODE_REPEAT: begin
            advance = 1'b1;
            if (status.segment == dahr_pkg::SEG_RELEASE) begin
               adv_seg = dahr_pkg::SEG_DELAY;
            end
         end
         default: begin
            advance = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (nxt_seg_ff)
         dahr_pkg::SEG_DELAY:  frames_zero = status.delay_zero;
         dahr_pkg::SEG_ATTACK: frames_zero = status.attack_zero;
         default:              frames_zero = status.release_zero;
      endcase
      needs_div = (nxt_seg_ff != dahr_pkg::SEG_HOLD) && !frames_zero;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      nxt_seg_in   = nxt_seg_ff;
      apply_in     = apply_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.seg_sel  = nxt_seg_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            apply_in = 1'b0;
            case (status.action)
               dahr_pkg::ACT_TICK: begin
                  if (status.segment == dahr_pkg::SEG_IDLE) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.frame_step = 1'b1;
                     if (status.expiring && advance) begin
                        nxt_seg_in = adv_seg;
                        apply_in   = 1'b1;
                        state_in   = S_ENTER;
                     end else begin
                        state_in = S_APPLY;
                     end
                  end
               end
               dahr_pkg::ACT_KEY_ON: begin
                  cmd.key_on = 1'b1;
                  nxt_seg_in = dahr_pkg::SEG_DELAY;
                  state_in   = S_ENTER;
               end
               dahr_pkg::ACT_KEY_OFF: begin
                  if (status.release_enable && !status.ignore_flag) begin
                     nxt_seg_in = dahr_pkg::SEG_RELEASE;
                     state_in   = S_ENTER;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_ENTER: begin
            cmd.enter     = 1'b1;
            cmd.div_start = needs_div;
            if (needs_div) begin
               state_in = S_DIV;
            end else if (apply_ff) begin
               state_in = S_APPLY;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.slope_load = 1'b1;
               state_in       = apply_ff ? S_APPLY : S_FINISH;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            // hold the result until the output register frees up
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nxt_seg_ff   <= dahr_pkg::SEG_IDLE;
         apply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nxt_seg_ff   <= nxt_seg_in;
         apply_ff     <= apply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `DAHR_ASSERT_NOW(a_no_rsp_overwrite, cmd.load_rsp, out_free, "unread word overwritten")
   `DAHR_ASSERT_NOW(a_div_done_in_div, status.div_done, state_ff == S_DIV,
                    "divider finished outside the divide state")

endmodule

`default_nettype wire

// File: rtl/dahr_dp.sv
// datapath: registers, level accumulator, slope, frame counter and divider
`default_nettype none

module dahr_dp #(
   parameter int FRAME_BITS      = dahr_pkg::FRAME_BITS_DEFAULT,
   parameter int LEVEL_FRAC_BITS = dahr_pkg::LEVEL_FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire dahr_pkg::dahr_cmd_type               cmd,
   output dahr_pkg::dahr_status_type                 status,
   input  wire logic [dahr_pkg::ACTION_W-1:0]        req_action,
   input  wire logic                                 req_ignore_release,
   input  wire logic                                 csr_write,
   input  wire logic [dahr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [FRAME_BITS-1:0]                csr_data,
   output logic [dahr_pkg::OUT_LEVEL_W-1:0]          rsp_level,
   output logic [dahr_pkg::SEG_W-1:0]                rsp_segment
);

`include "dahr_envelope_generator_macros.svh"

   localparam int LW = LEVEL_FRAC_BITS + 1;   // level, Q1.F unsigned
   localparam int SW = LEVEL_FRAC_BITS + 2;   // slope, signed
   localparam int XW = LEVEL_FRAC_BITS + 3;   // level plus slope
   localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

   logic [dahr_pkg::ACTION_W-1:0] act_ff, act_in;
   logic                          ign_req_ff, ign_req_in;
   logic                          ign_flag_ff, ign_flag_in;
   logic [dahr_pkg::SEG_W-1:0]    seg_ff, seg_in;
   logic [LW-1:0]                 level_ff, level_in;
   logic signed [SW-1:0]          slope_ff, slope_in;
   logic [FRAME_BITS-1:0]         frames_ff, frames_in;
   logic                          div_neg_ff, div_neg_in;
   logic [dahr_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [FRAME_BITS-1:0]         delay_ff, delay_in;
   logic [FRAME_BITS-1:0]         attack_ff, attack_in;
   logic [FRAME_BITS-1:0]         release_ff, release_in;
   logic                          rel_ena_ff, rel_ena_in;
   logic [dahr_pkg::OUT_LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [dahr_pkg::SEG_W-1:0]       rsp_seg_ff, rsp_seg_in;

   logic [FRAME_BITS-1:0] enter_frames;
   logic                  enter_attack;
   logic [LW-1:0]         div_dividend;
   logic                  div_done;
   logic [LW-1:0]         div_quotient;
   logic [SW-1:0]         quo_mag;
   logic signed [XW-1:0]  level_sum;
   logic [LW-1:0]         level_clip;

   always_comb begin
      case (cmd.seg_sel)
         dahr_pkg::SEG_DELAY:  enter_frames = delay_ff;
         dahr_pkg::SEG_ATTACK: enter_frames = attack_ff;
         default:              enter_frames = release_ff;
      endcase
      enter_attack = (cmd.seg_sel == dahr_pkg::SEG_ATTACK);
      // attack ramps up to one, the others ramp down to zero
      div_dividend = enter_attack ? (LEVEL_ONE - level_ff) : level_ff;
   end

   dahr_div #(
      .DIVIDEND_W (LW),
      .DIVISOR_W  (FRAME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (enter_frames),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      quo_mag    = {1'b0, div_quotient};
      level_sum  = $signed({2'b00, level_ff}) + $signed({slope_ff[SW-1], slope_ff});
      if (level_sum[XW-1]) begin
         level_clip = '0;
      end else if (level_sum[XW-2:0] > {1'b0, LEVEL_ONE}) begin
         level_clip = LEVEL_ONE;
      end else begin
         level_clip = level_sum[LW-1:0];
      end
   end

   always_comb begin
      act_in       = act_ff;
      ign_req_in   = ign_req_ff;
      ign_flag_in  = ign_flag_ff;
      seg_in       = seg_ff;
      level_in     = level_ff;
      slope_in     = slope_ff;
      frames_in    = frames_ff;
      div_neg_in   = div_neg_ff;
      mode_in      = mode_ff;
      delay_in     = delay_ff;
      attack_in    = attack_ff;
      release_in   = release_ff;
      rel_ena_in   = rel_ena_ff;
      rsp_level_in = rsp_level_ff;
      rsp_seg_in   = rsp_seg_ff;

      if (cmd.capture) begin
         act_in     = req_action;
         ign_req_in = req_ignore_release;
      end
      if (cmd.frame_step && (frames_ff != '0)) begin
         frames_in = frames_ff - 1'b1;
      end
      if (cmd.key_on) begin
         ign_flag_in = ign_req_ff;
         level_in    = '0;
      end
      if (cmd.enter) begin
         seg_in = cmd.seg_sel;
         if (cmd.seg_sel == dahr_pkg::SEG_HOLD) begin
            // hold keeps the frame counter, so it lasts one frame
            level_in = LEVEL_ONE;
            slope_in = '0;
         end else begin
            frames_in = enter_frames;
            if (enter_frames == '0) begin
               level_in = enter_attack ? LEVEL_ONE : '0;
               slope_in = '0;
            end
         end
      end
      if (cmd.div_start) begin
         div_neg_in = !enter_attack;
      end
      if (cmd.slope_load) begin
         slope_in = div_neg_ff ? $signed(-quo_mag) : $signed(quo_mag);
      end
      if (cmd.apply) begin
         level_in = level_clip;
      end
      if (cmd.load_rsp) begin
         rsp_level_in = level_ff[LEVEL_FRAC_BITS -: dahr_pkg::OUT_LEVEL_W];
         rsp_seg_in   = seg_ff;
      end

      if (csr_write) begin
         case (csr_index)
            dahr_pkg::REG_MODE:        mode_in    = csr_data[dahr_pkg::MODE_W-1:0];
            dahr_pkg::REG_DELAY:       delay_in   = csr_data;
            dahr_pkg::REG_ATTACK:      attack_in  = csr_data;
            dahr_pkg::REG_RELEASE:     release_in = csr_data;
            dahr_pkg::REG_RELEASE_ENA: rel_ena_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ign_flag_ff <= 1'b0;
         seg_ff      <= dahr_pkg::SEG_IDLE;
         level_ff    <= '0;
         slope_ff    <= '0;
         frames_ff   <= '0;
         mode_ff     <= dahr_pkg::MODE_NORMAL;
         delay_ff    <= '0;
         attack_ff   <= '0;
         release_ff  <= '0;
         rel_ena_ff  <= 1'b1;
      end else begin
         ign_flag_ff <= ign_flag_in;
         seg_ff      <= seg_in;
         level_ff    <= level_in;
         slope_ff    <= slope_in;
         frames_ff   <= frames_in;
         mode_ff     <= mode_in;
         delay_ff    <= delay_in;
         attack_ff   <= attack_in;
         release_ff  <= release_in;
         rel_ena_ff  <= rel_ena_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      ign_req_ff   <= ign_req_in;
      div_neg_ff   <= div_neg_in;
      rsp_level_ff <= rsp_level_in;
      rsp_seg_ff   <= rsp_seg_in;
   end

   always_comb begin
      status                = '0;
      status.action         = act_ff;
      status.segment        = seg_ff;
      status.expiring       = (frames_ff[FRAME_BITS-1:1] == '0);
      status.ignore_flag    = ign_flag_ff;
      status.mode           = mode_ff;
      status.release_enable = rel_ena_ff;
      status.delay_zero     = (delay_ff == '0);
      status.attack_zero    = (attack_ff == '0);
      status.release_zero   = (release_ff == '0);
      status.div_done       = div_done;
   end

   assign rsp_level   = rsp_level_ff;
   assign rsp_segment = rsp_seg_ff;

   `DAHR_ASSERT_NOW(a_level_in_range, 1'b1, level_ff <= LEVEL_ONE, "level above full scale")
   `DAHR_ASSERT_NOW(a_idle_is_quiet, seg_ff == dahr_pkg::SEG_IDLE,
                    level_ff == '0 && slope_ff == '0, "idle with nonzero level or slope")

endmodule

`default_nettype wire

// File: rtl/dahr_envelope_generator.sv
// Delay-attack-hold-release envelope generator, one result word per request word.
//
// Channels: req_ch carries action (tick, key on, key off) and ignore_release;
// rsp_ch returns the level in Q1.16 and the segment after that action; csr_ch
// writes the mode, the three segment lengths in frames and the release enable.
// The register channel is always ready; write only while no word is in flight.
//
// Divide: a word that enters a delay, attack or release segment with a nonzero
// length runs the serial divider, one quotient bit per cycle. One word is worked
// on at a time; the next is accepted the cycle after the result is loaded into
// the output register.
//
// Reset clears the segment to idle, level, slope and frame counter to zero,
// the configuration registers to zero except release enable, which comes up set.
// A stalled receiver holds the result in the output register; one more word
// may be taken and worked, then the block waits until the held word is taken.
`default_nettype none

module dahr_envelope_generator #(
   parameter int FRAME_BITS      = dahr_pkg::FRAME_BITS_DEFAULT,
   parameter int LEVEL_FRAC_BITS = dahr_pkg::LEVEL_FRAC_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   dahr_req_if.sink   req_ch,
   dahr_rsp_if.source rsp_ch,
   dahr_csr_if.sink   csr_ch
);

   dahr_pkg::dahr_cmd_type    cmd;
   dahr_pkg::dahr_status_type status;
   logic                      csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   dahr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dahr_dp #(
      .FRAME_BITS      (FRAME_BITS),
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_ch.action),
      .req_ignore_release (req_ch.ignore_release),
      .csr_write          (csr_write),
      .csr_index          (csr_ch.index),
      .csr_data           (FRAME_BITS'(csr_ch.data)),
      .rsp_level          (rsp_ch.level),
      .rsp_segment        (rsp_ch.segment)
   );

endmodule

`default_nettype wire
